>>> rtl/fm_modulator_nco_defines.svh
// Assertion macros for the FM modulator NCO.
// Included by files that check their own logic; expects clock and reset in scope.
`ifndef FM_MODULATOR_NCO_DEFINES_SVH
`define FM_MODULATOR_NCO_DEFINES_SVH

// Same-cycle implication, off during reset.
`define FMN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define FMN_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fmn_pkg.sv
// Shared constants, types and the cosine table function of the FM modulator NCO.
// No dependencies.
`default_nettype none

package fmn_pkg;

   localparam int PHASE_BITS_DEF      = 32;
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int TABLE_ADDR_BITS_DEF = 10;

   localparam int MESSAGE_W   = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;
   localparam int CFG_W       = 32;
   localparam int AMP_W       = 15;
   localparam int GAIN_PROD_W = 48;
   localparam int INC_W       = GAIN_PROD_W - 15;
   localparam int ROM_W       = 31;
   localparam int AMP_PROD_W  = AMP_W + ROM_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int WIDE_W      = 64;

   localparam logic [AMP_W-1:0]  AMP_RESET   = 15'h7FFF;
   localparam logic [WIDE_W-1:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [WIDE_W-1:0] Q30_ONE     = 64'd1 << 30;

   localparam int TAYLOR_TERMS = 10;
   // (2k-1)*2k for k = 1..10
   localparam logic [WIDE_W-1:0] TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CARRIER_STEP = 2'd0,
      CSR_FM_GAIN      = 2'd1,
      CSR_AMPLITUDE    = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic ld_prod;
      logic ld_out;
   } out_ctl_type;

   // Quarter-wave cosine entry i in Q1.30, Taylor series evaluated at elaboration.
   function automatic logic [ROM_W-1:0] cos_entry(input int unsigned i,
                                                  input int unsigned addr_bits);
      logic [WIDE_W-1:0]        x;
      logic [WIDE_W-1:0]        x2;
      logic [WIDE_W-1:0]        term;
      logic signed [WIDE_W-1:0] sum;
      x    = (WIDE_W'(i) * HALF_PI_Q30 + (64'd1 << (addr_bits - 1))) >> addr_bits;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = $signed(Q30_ONE);
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
         term = (term * x2) / TAYLOR_DIV[k];
         if (k[0] == 1'b0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(Q30_ONE)) begin
         sum = $signed(Q30_ONE);
      end
      return sum[ROM_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/fmn_phase_acc.sv
// Carrier and deviation phase accumulators with the registered summed phase.
// Depends on fmn_pkg.
`default_nettype none

module fmn_phase_acc #(
   parameter int PHASE_BITS = fmn_pkg::PHASE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic signed [fmn_pkg::MESSAGE_W-1:0] message,
   input  logic                               first,
   input  logic [fmn_pkg::CFG_W-1:0]          carrier_step,
   input  logic signed [fmn_pkg::CFG_W-1:0]   fm_gain,
   output logic [PHASE_BITS-1:0]              phase_ff
);
   import fmn_pkg::*;

   logic [PHASE_BITS-1:0]         carrier_ff, carrier_in;
   logic [PHASE_BITS-1:0]         dev_ff, dev_in;
   logic [PHASE_BITS-1:0]         inc_ff, inc_in;
   logic [PHASE_BITS-1:0]         phase_in;
   logic [PHASE_BITS-1:0]         carrier_base;
   logic [PHASE_BITS-1:0]         step_p;
   logic [WIDE_W-1:0]             step_wide;
   logic signed [GAIN_PROD_W-1:0] gain_prod;
   logic signed [INC_W-1:0]       inc_s;
   logic [WIDE_W-1:0]             inc_wide;

   assign step_wide = {{(WIDE_W - CFG_W){1'b0}}, carrier_step};
   assign step_p    = step_wide[PHASE_BITS-1:0];

   // floor(message * gain / 2^15), wrapped to the phase width
   assign gain_prod = GAIN_PROD_W'(message) * GAIN_PROD_W'(fm_gain);
   assign inc_s     = gain_prod[GAIN_PROD_W-1:15];
   assign inc_wide  = {{(WIDE_W - INC_W){inc_s[INC_W-1]}}, inc_s};

   // the pending increment belongs to the previous word; drop it on first
   always_comb begin
      carrier_base = first ? '0 : carrier_ff;
      dev_in       = first ? '0 : dev_ff + inc_ff;
      phase_in     = carrier_base + dev_in;
      carrier_in   = carrier_base + step_p;
      inc_in       = inc_wide[PHASE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff <= '0;
         dev_ff     <= '0;
         inc_ff     <= '0;
      end else if (accept) begin
         carrier_ff <= carrier_in;
         dev_ff     <= dev_in;
         inc_ff     <= inc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fmn_cos_rom.sv
// Quarter-wave cosine ROM, 2^ADDR_BITS + 1 entries in Q1.30, registered read.
// Depends on fmn_pkg (cos_entry).
`default_nettype none

module fmn_cos_rom #(
   parameter int ADDR_BITS = fmn_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ADDR_BITS:0]        rd_addr,
   output logic [fmn_pkg::ROM_W-1:0] rd_data_ff
);
   import fmn_pkg::*;

   localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1;

   logic [ROM_W-1:0] rom_w [DEPTH];

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
      localparam logic [ROM_W-1:0] ENTRY = cos_entry(gi, ADDR_BITS);
      assign rom_w[gi] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_w[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/fmn_amp_out.sv
// Amplitude scaling, rounding, saturation and sign of the output sample.
// Depends on fmn_pkg.
`default_nettype none

module fmn_amp_out #(
   parameter int SAMPLE_BITS = fmn_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  fmn_pkg::out_ctl_type           ctl,
   input  logic [fmn_pkg::AMP_W-1:0]      amplitude,
   input  logic [fmn_pkg::ROM_W-1:0]      cos_mag,
   input  logic                           negate,
   output logic [fmn_pkg::RSP_DATA_W-1:0] signal_ff
);
   import fmn_pkg::*;

   localparam int SH = AMP_PROD_W - SAMPLE_BITS;
   localparam logic [AMP_PROD_W-1:0]  RND = AMP_PROD_W'(1) << (SH - 1);
   localparam logic [SAMPLE_BITS-1:0] LIM = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

   logic [AMP_PROD_W-1:0]  prod_ff, prod_in;
   logic                   neg_ff, neg_in;
   logic [AMP_PROD_W-1:0]  rounded;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] sat;
   logic [SAMPLE_BITS-1:0] val;
   logic [WIDE_W-1:0]      val_wide;
   logic [RSP_DATA_W-1:0]  signal_in;

   assign prod_in = AMP_PROD_W'(amplitude) * AMP_PROD_W'(cos_mag);
   assign neg_in  = negate;

   always_ff @(posedge clock) begin
      if (ctl.ld_prod) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
   end

   always_comb begin
      rounded   = prod_ff + RND;
      mag       = rounded[AMP_PROD_W-1:SH];
      sat       = (mag > LIM) ? LIM : mag;
      val       = neg_ff ? (~sat + 1'b1) : sat;
      val_wide  = {{(WIDE_W - SAMPLE_BITS){val[SAMPLE_BITS-1]}}, val};
      signal_in = val_wide[RSP_DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_out) begin
         signal_ff <= signal_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fm_modulator_nco.sv
// Top level of the FM modulator NCO: register port, pipeline control, assertions.
// Depends on fmn_pkg, fmn_phase_acc, fmn_cos_rom, fmn_amp_out and the defines header.
//
//   channel   direction   payload
//   req_      in          tdata[15:0] message (signed), tuser[0] first
//   rsp_      out         tdata[15:0] signal (signed)
//   csr_      in/out      carrier_step @0x0, fm_gain @0x4, amplitude @0x8
//
// Takes one word per clock while the output does not stall the pipe.
// The phase accumulator add is the only loop, closed through its own register.
// Four stages: summed phase, cosine ROM read, amplitude product, round and saturate.
// Each stage holds its word while the next holds, so bubbles close up under stalls.
// Synchronous active-high reset clears phases, valid bits and registers to defaults.
`default_nettype none
`include "fm_modulator_nco_defines.svh"

module fm_modulator_nco #(
   parameter int PHASE_BITS      = fmn_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS     = fmn_pkg::SAMPLE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = fmn_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input words
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fmn_pkg::REQ_DATA_W-1:0] req_tdata,   // [15:0] message
   input  logic [0:0]                     req_tuser,   // [0] first
   // result words
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fmn_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [15:0] signal
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fmn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fmn_pkg::CFG_W-1:0]      csr_pwdata,
   output logic [fmn_pkg::CFG_W-1:0]      csr_prdata,
   output logic                           csr_pready
);
   import fmn_pkg::*;

   // registers
   logic [CFG_W-1:0]        carrier_step_ff;
   logic signed [CFG_W-1:0] fm_gain_ff;
   logic [AMP_W-1:0]        amplitude_ff;
   logic                    csr_wr;
   csr_reg_type             csr_idx;

   // pipeline control
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic vout_ff, vout_in;
   logic ld1, ld2, ld3, ld_out;
   logic accept;

   // datapath
   logic [PHASE_BITS-1:0]      phase_q;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] idx;
   logic [TABLE_ADDR_BITS:0]   rom_addr;
   logic [ROM_W-1:0]           cos_mag;
   logic                       neg2_ff, neg2_in;
   out_ctl_type                out_ctl;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_step_ff <= '0;
         fm_gain_ff      <= '0;
         amplitude_ff    <= AMP_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_CARRIER_STEP: carrier_step_ff <= csr_pwdata;
            CSR_FM_GAIN:      fm_gain_ff      <= $signed(csr_pwdata);
            CSR_AMPLITUDE:    amplitude_ff    <= csr_pwdata[AMP_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_CARRIER_STEP: csr_prdata = carrier_step_ff;
         CSR_FM_GAIN:      csr_prdata = fm_gain_ff;
         CSR_AMPLITUDE:    csr_prdata = {{(CFG_W - AMP_W){1'b0}}, amplitude_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // a stage loads when it is empty or its word moves on this cycle
   always_comb begin
      ld_out = !vout_ff || rsp_tready;
      ld3    = !v3_ff || ld_out;
      ld2    = !v2_ff || ld3;
      ld1    = !v1_ff || ld2;
      accept = req_tvalid && ld1;
      v1_in  = ld1 ? req_tvalid : v1_ff;
      v2_in  = ld2 ? v1_ff : v2_ff;
      v3_in  = ld3 ? v2_ff : v3_ff;
      vout_in = ld_out ? v3_ff : vout_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         vout_ff <= vout_in;
      end
   end

   assign req_tready = ld1;
   assign rsp_tvalid = vout_ff;

   // ---------------- stage 1: summed phase ----------------
   fmn_phase_acc #(
      .PHASE_BITS(PHASE_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .message     ($signed(req_tdata[MESSAGE_W-1:0])),
      .first       (req_tuser[0]),
      .carrier_step(carrier_step_ff),
      .fm_gain     (fm_gain_ff),
      .phase_ff    (phase_q)
   );

   // ---------------- stage 2: quarter-wave lookup ----------------
   // odd quadrants read the table mirrored; quadrants 1 and 2 are negative
   always_comb begin
      quad     = phase_q[PHASE_BITS-1 -: 2];
      idx      = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      rom_addr = quad[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, idx}) : {1'b0, idx};
      neg2_in  = quad[1] ^ quad[0];
   end

   fmn_cos_rom #(
      .ADDR_BITS(TABLE_ADDR_BITS)
   ) u_rom (
      .clock     (clock),
      .rd_en     (ld2),
      .rd_addr   (rom_addr),
      .rd_data_ff(cos_mag)
   );

   always_ff @(posedge clock) begin
      if (ld2) begin
         neg2_ff <= neg2_in;
      end
   end

   // ---------------- stages 3 and 4: scale and finish ----------------
   assign out_ctl.ld_prod = ld3;
   assign out_ctl.ld_out  = ld_out;

   fmn_amp_out #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_out (
      .clock    (clock),
      .ctl      (out_ctl),
      .amplitude(amplitude_ff),
      .cos_mag  (cos_mag),
      .negate   (neg2_ff),
      .signal_ff(rsp_tdata)
   );

   // ---------------- assertions ----------------
   `FMN_ASSERT_NXT(a_first_zero, accept && req_tuser[0], phase_q == '0, "first word off zero")
   `FMN_ASSERT_NXT(a_accept_fills_s1, accept, v1_ff, "accepted word lost at stage one")
   `FMN_ASSERT_IMP(a_full_stall, v1_ff && v2_ff && !ld3, !req_tready, "ready high on full stall")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for the FM modulator NCO: stream words in, cosine samples out.
// Depends on fmn_pkg for port widths and register codes; needs the RTL and nothing else.
`default_nettype none

module tb_top;
   import fmn_pkg::*;

   // Table geometry at the block's default parameters
   localparam int TABLE_BITS   = TABLE_ADDR_BITS_DEF;
   localparam int TABLE_SIZE   = 1 << TABLE_BITS;
   localparam int TOP_SHIFT    = PHASE_BITS_DEF - TABLE_BITS - 2;
   localparam int ROUND_SHIFT  = 46 - SAMPLE_BITS_DEF;
   localparam int SIGNAL_MAX   = (1 << (SAMPLE_BITS_DEF - 1)) - 1;

   // Register index past the end of the map; writes to it must be dropped
   localparam int SPARE_REG_INDEX = 3;

   localparam int NUM_PHASES      = 10;
   localparam int WORDS_PER_PHASE = 123;
   localparam int QUIET_LIMIT     = 2000;
   localparam int MAX_PRINTED     = 100;

   // ------------------------------------------------------------------
   // Predict each signal word from the message stream and compare
   // ------------------------------------------------------------------
   class fm_signal_scoreboard;
      logic [31:0]        carrier_step;
      logic signed [31:0] fm_gain;
      logic [AMP_W-1:0]   amplitude;
      logic [31:0]        carrier_phase;
      logic [31:0]        deviation_phase;
      logic [30:0]        cos_quarter [0:TABLE_SIZE];
      logic [15:0]        expected_signal [$];
      int                 errors;
      int                 words_in;
      int                 words_out;
      int                 restarts;

      function new();
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint          sum;
         // Quarter-wave cosine in Q1.30 from a ten-term Taylor series
         for (int i = 0; i <= TABLE_SIZE; i++) begin
            x    = (longint'(i) * 64'd1686629713 + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(64'd1 << 30);
            for (int k = 1; k <= 10; k++) begin
               term = (term * x2) / longint'((2 * k - 1) * (2 * k));
               if (k % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) sum = 0;
            if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
            cos_quarter[i] = sum[30:0];
         end
         carrier_step    = '0;
         fm_gain         = '0;
         amplitude       = AMP_RESET;
         carrier_phase   = '0;
         deviation_phase = '0;
         errors          = 0;
         words_in        = 0;
         words_out       = 0;
         restarts        = 0;
      endfunction

      function void set_register(input int index, input logic [31:0] value);
         case (index)
            CSR_CARRIER_STEP: carrier_step = value;
            CSR_FM_GAIN:      fm_gain      = $signed(value);
            CSR_AMPLITUDE:    amplitude    = value[AMP_W-1:0];
            default:          ;
         endcase
      endfunction

      // Note an accepted message word: queue its signal, then advance both phases
      function void predict_signal(input logic signed [15:0] message, input logic first);
         logic [31:0]     total;
         logic [1:0]      quad;
         logic [9:0]      index;
         logic [30:0]     entry;
         longint unsigned mag;
         longint          dev_step;
         logic [15:0]     signal;
         if (first) begin
            carrier_phase   = '0;
            deviation_phase = '0;
            restarts++;
         end
         total = carrier_phase + deviation_phase;
         quad  = total[31:30];
         index = total[TOP_SHIFT +: TABLE_BITS];
         entry = quad[0] ? cos_quarter[TABLE_SIZE - index] : cos_quarter[index];
         mag   = (longint'(amplitude) * entry + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
         if (mag > SIGNAL_MAX) mag = SIGNAL_MAX;
         signal = mag[15:0];
         if (quad == 2'd1 || quad == 2'd2) signal = -signal;
         expected_signal.push_back(signal);
         words_in++;
         carrier_phase   = carrier_phase + carrier_step;
         dev_step        = (longint'(message) * longint'(fm_gain)) >>> 15;
         deviation_phase = deviation_phase + dev_step[31:0];
      endfunction

      task report_mismatch(input string what);
         errors++;
         if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_signal(input logic [15:0] got);
         logic [15:0] want;
         words_out++;
         if (expected_signal.size() == 0) begin
            report_mismatch($sformatf("signal word %0d %h arrived with nothing expected",
                                      words_out, got));
         end else begin
            want = expected_signal.pop_front();
            if (got !== want)
               report_mismatch($sformatf("signal word %0d: got %h, expected %h",
                                         words_out, got, want));
         end
      endtask

      task check_drained();
         if (expected_signal.size() != 0)
            report_mismatch($sformatf("%0d signal words never arrived",
                                      expected_signal.size()));
      endtask
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;    // [15:0] message
   logic [0:0]            req_tuser   = '0;    // [0] first
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // [15:0] signal
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CFG_W-1:0]      csr_pwdata  = '0;
   logic [CFG_W-1:0]      csr_prdata;
   logic                  csr_pready;

   bit req_idling = 1'b0;
   bit rsp_idling = 1'b0;
   int settings   = 0;

   fm_signal_scoreboard sb = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fm_modulator_nco dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------
   // Driver tasks: change inputs on the falling edge, sample on the rising
   // ------------------------------------------------------------------

   // Register write with a setup phase and an access phase; mirror it into the predictor once it lands
   task automatic csr_write(input int index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one message word, maybe after an idle burst; hold it until taken.
   // tvalid stays high into the next call so back-to-back words need no gap.
   task automatic send_word(input logic [15:0] message, input logic first);
      int gap;
      @(negedge clock);
      if (req_idling && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= message;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      sb.predict_signal(message, first);
   endtask

   // Drop tvalid and wait out every expected signal word plus the pipe depth
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_signal.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] step, input logic [31:0] gain,
                                 input logic [31:0] amp);
      csr_write(CSR_CARRIER_STEP, step);
      csr_write(CSR_FM_GAIN, gain);
      csr_write(CSR_AMPLITUDE, amp);
      settings++;
   endtask

   // ------------------------------------------------------------------
   // Result side: stall in random bursts, check every accepted word
   // ------------------------------------------------------------------
   initial begin : signal_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idling && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_signal(rsp_tdata);
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if no handshake of any kind happens for too long
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] step;
      logic [31:0] gain;
      logic [31:0] amp;
      logic [15:0] message;
      logic        first;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: no carrier, no deviation, full amplitude -> flat +1.0
      send_word(16'h7FFF, 1'b1);
      send_word(16'h8000, 1'b0);
      drain();

      // Quarter-turn carrier lands exactly on each quadrant boundary in turn;
      // full positive gain so message extremes swing the deviation hardest
      apply_settings(32'h4000_0000, 32'h7FFF_FFFF, 32'd32767);
      send_word(16'h0000, 1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h7FFF, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0001, 1'b0);
      // Restart mid-message: output must come from phase zero again
      send_word(16'h8000, 1'b1);
      send_word(16'h5555, 1'b0);
      drain();

      // Most negative gain, zero amplitude, carrier one step short of a turn;
      // a write past the register map must leave all of this untouched
      apply_settings(32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
      csr_write(SPARE_REG_INDEX, 32'hFFFF_FFFF);
      send_word(16'h7FFF, 1'b1);
      send_word(16'h8000, 1'b0);
      send_word(16'hAAAA, 1'b0);
      drain();

      // Smallest nonzero amplitude and gain
      apply_settings(32'h0123_4567, 32'h0000_0001, 32'd1);
      send_word(16'h7FFF, 1'b1);
      send_word(16'h8000, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h7FFF, 1'b0);
      drain();

      // Random phases: fresh settings each time, idling only in the early ones
      for (int p = 0; p < NUM_PHASES; p++) begin
         case ($urandom_range(0, 4))
            0:       step = 32'h0000_0000;
            1:       step = 32'hFFFF_FFFF;
            2:       step = 32'h8000_0000;
            3:       step = $urandom_range(0, 32'h0200_0000);
            default: step = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0:       gain = 32'h7FFF_FFFF;
            1:       gain = 32'h8000_0000;
            2:       gain = 32'h0000_0000;
            3:       gain = 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
            default: gain = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       amp = 32'd32767;
            1:       amp = 32'd0;
            default: amp = $urandom_range(1, 32767);
         endcase
         apply_settings(step, gain, amp);

         req_idling = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         rsp_idling = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);

         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            case ($urandom_range(0, 15))
               0:       message = 16'h8000;
               1:       message = 16'h7FFF;
               2:       message = 16'h0000;
               default: message = 16'($urandom);
            endcase
            first = (n == 0) || ($urandom_range(0, 40) == 0);
            send_word(message, first);
         end
         drain();
      end

      sb.check_drained();
      $display("Sent %0d message words (%0d phase restarts) under %0d register settings;",
               sb.words_in, sb.restarts, settings);
      $display("checked %0d signal words, %0d mismatches.", sb.words_out, sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
